/* hdl/dqe_pkg.sv */
// package for the double-ended queue: request and status codes, fixed field widths
// no dependencies
package dqe_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_HEAD = 2'd0,
    REQ_POP_HEAD  = 2'd1,
    REQ_PUSH_TAIL = 2'd2,
    REQ_POP_TAIL  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

/* hdl/dqe_ram.sv */
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
module dqe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/double_ended_queue.sv */
// bounded double-ended queue of signed 32-bit values, top level
// depends on dqe_pkg and dqe_ram
//
// Each request pushes or pops one value at the head end or the tail end of a
// ring of DEPTH entries held in one synchronous ram. The block takes one
// request per cycle as long as results are taken and returns exactly one
// result per request: on acceptance it updates the head index, the tail index
// and the count and issues the ram access into the issue stage, which then
// carries the registered ram read data into the output register; the issue
// stage covers the registered read of the ram. A pop from an empty queue
// returns status empty and value 0; a push to a full queue is refused with
// status full. Every result carries the entry count after the request,
// reduced to 5 bits. Pop results of pushes read 0. Entries need no clearing
// after reset, since a pop only reads slots that a push has written.
module double_ended_queue
  import dqe_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] pop_value, [36:32] entry_count, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  // ring pointers and count
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // neighbor slots of the two ends
  logic [IW-1:0] head_next, head_prev, tail_next, tail_prev;

  // ram access of the current request
  logic          op_wr, op_rd;
  logic [IW-1:0] op_addr;
  status_t       op_status;
  logic [31:0]   rd_data;

  // issue stage: request whose ram read is in flight
  logic          s1_valid_r;
  logic          s1_pop_r;
  status_t       s1_status_r;
  logic [CountW-1:0] s1_count_r;

  // output register
  logic          out_valid_r;
  logic [31:0]   out_value_r;
  status_t       out_status_r;
  logic [CountW-1:0] out_count_r;

  logic accept, out_free, s1_adv, empty, full;
  req_t req;

  assign req      = req_t'(in_tuser);
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == FullCnt);
  assign out_free = !out_valid_r || out_tready;
  assign s1_adv   = s1_valid_r && out_free;
  // a new request may enter whenever the issue stage is empty or drains this cycle
  assign in_tready = !s1_valid_r || out_free;
  assign accept    = in_tvalid && in_tready;

  // ring wrap without modulo so any depth works
  assign head_next = (head_r == LastIdx) ? '0 : head_r + 1'b1;
  assign head_prev = (head_r == '0) ? LastIdx : head_r - 1'b1;
  assign tail_next = (tail_r == LastIdx) ? '0 : tail_r + 1'b1;
  assign tail_prev = (tail_r == '0) ? LastIdx : tail_r - 1'b1;

  // decode the request into one ram access and the new pointer values
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    op_wr     = 1'b0;
    op_rd     = 1'b0;
    op_addr   = head_r;
    op_status = ST_OK;
    case (req)
      REQ_PUSH_HEAD: begin
        if (full) begin
          op_status = ST_FULL;
        end else begin
          op_wr    = 1'b1;
          op_addr  = head_r;
          head_nxt = head_next;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      REQ_POP_HEAD: begin
        if (empty) begin
          op_status = ST_EMPTY;
        end else begin
          op_rd    = 1'b1;
          op_addr  = head_prev;
          head_nxt = head_prev;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      REQ_PUSH_TAIL: begin
        if (full) begin
          op_status = ST_FULL;
        end else begin
          op_wr    = 1'b1;
          op_addr  = tail_prev;
          tail_nxt = tail_prev;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      REQ_POP_TAIL: begin
        if (empty) begin
          op_status = ST_EMPTY;
        end else begin
          op_rd    = 1'b1;
          op_addr  = tail_r;
          tail_nxt = tail_next;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      default: begin
        op_status = ST_OK;
      end
    endcase
  end

  // every request touches one slot only, so a read and a write never meet in
  // the same cycle; a read right after a write sees the new data because the
  // write lands at the edge before the read samples the array
  dqe_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept && op_wr),
    .wr_addr (op_addr),
    .wr_data (in_tdata),
    .rd_en   (accept && op_rd),
    .rd_addr (op_addr),
    .rd_data (rd_data)
  );

  // pointer and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // issue stage; the ram read data holds while the stage stalls because no
  // new read is issued until it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop_r    <= op_rd;
      s1_status_r <= op_status;
      s1_count_r  <= CountW'(cnt_nxt);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r  <= s1_pop_r ? rd_data : '0;
      out_status_r <= s1_status_r;
      out_count_r  <= s1_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_value_r};
  assign out_tuser  = out_status_r;

endmodule

/* hdl/dqe_chk.sv */
// port-level checker for the double-ended queue, bound to the top level
// depends on dqe_pkg and double_ended_queue
module dqe_chk
  import dqe_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  localparam logic [CountW-1:0] FullCnt = CountW'(DEPTH);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // pop from empty leaves nothing and returns zero
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[36:0] == '0)
    else $error("empty status with nonzero value or count");

  // refused push reports a full queue and no value
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |->
      out_tdata[36:32] == FullCnt && out_tdata[31:0] == '0)
    else $error("full status with wrong count or value");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind double_ended_queue dqe_chk #(.DEPTH(DEPTH)) u_dqe_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
